### rtl/lruc_pkg.sv
// Shared types and constants for the LRU associative cache.
// No dependencies; every other file refers to this package by scoped names.
package lruc_pkg;

    localparam int MODE_W    = 2;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 16;
    localparam int CFG_W     = 4;
    localparam int OCC_W     = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;
    localparam logic [OCC_W-1:0] OCC_MAX      = 4'd15;

    // Command queue between front and back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = 1;
    localparam int Q_FW    = 2;

    localparam logic [MODE_W-1:0] MODE_GET      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUT      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

    typedef enum logic [3:0] {
        OP_GET      = 4'b0001,
        OP_PUT      = 4'b0010,
        OP_CONTAINS = 4'b0100,
        OP_CLEAR    = 4'b1000
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_item;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  avail;
        t_item item;
    } t_q_head;

endpackage

### rtl/lruc_front.sv
// Front end: accepts commands, decodes the mode and queues them for the back end.
// Depends on lruc_pkg.
module lruc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [lruc_pkg::MODE_W-1:0]     i_mode,
    input  logic [lruc_pkg::KEY_W-1:0]      i_key,
    input  logic [lruc_pkg::PAYLOAD_W-1:0]  i_payload,
    output lruc_pkg::t_q_head               o_head,
    input  logic                            i_pop
);

    lruc_pkg::t_item              r_q [lruc_pkg::Q_DEPTH];
    logic [lruc_pkg::Q_PW-1:0]    r_wr_ptr;
    logic [lruc_pkg::Q_PW-1:0]    r_rd_ptr;
    logic [lruc_pkg::Q_FW-1:0]    r_fill;
    lruc_pkg::t_op                op;
    logic                         push;
    logic                         pop;

    always_comb begin
        op = lruc_pkg::OP_GET;
        unique case (i_mode)
            lruc_pkg::MODE_GET:      op = lruc_pkg::OP_GET;
            lruc_pkg::MODE_PUT:      op = lruc_pkg::OP_PUT;
            lruc_pkg::MODE_CONTAINS: op = lruc_pkg::OP_CONTAINS;
            lruc_pkg::MODE_CLEAR:    op = lruc_pkg::OP_CLEAR;
        endcase
    end

    assign o_busy = (r_fill == lruc_pkg::Q_FW'(lruc_pkg::Q_DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{op: op, key: i_key, payload: i_payload};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    assign o_head.avail = (r_fill != '0);
    assign o_head.item  = r_q[r_rd_ptr];

endmodule

### rtl/lruc_back.sv
// Back end: slot storage, tag match, oldest-stamp search and slot update.
// Depends on lruc_pkg; fed by lruc_front.
module lruc_back #(
    parameter int SLOTS      = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lruc_pkg::t_q_head               i_head,
    output logic                            o_pop,
    input  logic [SLOTS-1:0]                i_active,
    output logic                            o_strobe,
    output logic                            o_hit,
    output logic [lruc_pkg::PAYLOAD_W-1:0]  o_data,
    output logic                            o_evicted,
    output logic [lruc_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TP = 1 << $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_LOOK  = 2'b01,
        S_WRITE = 2'b10
    } t_state;

    t_state                         r_state;
    t_state                         n_state;

    // Slot storage
    logic [SLOTS-1:0]               r_valid;
    logic [SLOTS-1:0]               n_valid;
    logic [lruc_pkg::KEY_W-1:0]     r_key     [SLOTS];
    logic [lruc_pkg::PAYLOAD_W-1:0] r_payload [SLOTS];
    logic [STAMP_BITS-1:0]          r_stamp   [SLOTS];
    logic [STAMP_BITS-1:0]          r_count;
    logic [STAMP_BITS-1:0]          n_count;

    // Lookup results
    lruc_pkg::t_op                  r_op;
    logic [lruc_pkg::KEY_W-1:0]     r_lk_key;
    logic [lruc_pkg::PAYLOAD_W-1:0] r_lk_payload;
    logic [lruc_pkg::PAYLOAD_W-1:0] r_lk_data;
    logic                           r_lk_hit;
    logic                           r_lk_evict;
    logic [IW-1:0]                  r_lk_idx;
    logic [CW-1:0]                  r_lk_cnt;

    // Output registers
    logic                           r_strobe;
    logic                           r_hit;
    logic [lruc_pkg::PAYLOAD_W-1:0] r_data;
    logic                           r_evict;
    logic [lruc_pkg::OCC_W-1:0]     r_occ;
    logic [lruc_pkg::OCC_W-1:0]     n_occ;

    logic [SLOTS-1:0]               live;
    logic                           match;
    logic [IW-1:0]                  match_idx;
    logic [IW-1:0]                  free_idx;
    logic                           full;
    logic [CW-1:0]                  cnt;
    logic [CW-1:0]                  cnt_after;
    logic                           look;
    logic                           store;
    logic                           bump;

    // Oldest-stamp tree: leaves at TP..2*TP-1, root at 1
    logic                           tv [2*TP];
    logic [STAMP_BITS-1:0]          ts [2*TP];
    logic [IW-1:0]                  ti [2*TP];

    assign look = (r_state == S_LOOK) && i_head.avail;
    assign o_pop = look;

    always_comb begin
        live      = r_valid & i_active;
        match     = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (live[i] && (r_key[i] == i_head.item.key)) begin
                match     = 1'b1;
                match_idx = IW'(i);
            end
            if (!live[i] && i_active[i]) begin
                free_idx = IW'(i);
            end
        end
        full = (live == i_active);
        cnt  = CW'($countones(live));
    end

    always_comb begin
        for (int j = 0; j < TP; j++) begin
            tv[TP + j] = 1'b0;
            ts[TP + j] = '0;
            ti[TP + j] = IW'(j);
            if (j < SLOTS) begin
                tv[TP + j] = live[j];
                ts[TP + j] = r_stamp[j];
            end
        end
        tv[0] = 1'b0;
        ts[0] = '0;
        ti[0] = '0;
        // Left child wins ties: it holds the lower slot index
        for (int k = TP - 1; k >= 1; k--) begin
            if (tv[2*k] && (!tv[2*k+1] || (ts[2*k] <= ts[2*k+1]))) begin
                tv[k] = tv[2*k];
                ts[k] = ts[2*k];
                ti[k] = ti[2*k];
            end else begin
                tv[k] = tv[2*k+1];
                ts[k] = ts[2*k+1];
                ti[k] = ti[2*k+1];
            end
        end
    end

    assign store = (r_state == S_WRITE) && (r_op == lruc_pkg::OP_PUT) && !r_lk_hit;
    assign bump  = (r_state == S_WRITE) &&
                   ((r_op == lruc_pkg::OP_PUT) || ((r_op == lruc_pkg::OP_GET) && r_lk_hit));

    always_comb begin
        n_count = (r_count != '1) ? r_count + 1'b1 : r_count;

        n_valid = r_valid;
        if (r_state == S_WRITE) begin
            if (r_op == lruc_pkg::OP_CLEAR) begin
                n_valid = '0;
            end else if (store) begin
                n_valid[r_lk_idx] = 1'b1;
            end
        end
        // Drop slots outside the active range
        n_valid = n_valid & i_active;

        // An eviction reuses the victim's slot, so only a plain store adds one
        cnt_after = r_lk_cnt;
        if (r_op == lruc_pkg::OP_CLEAR) begin
            cnt_after = '0;
        end else if (store && !r_lk_evict) begin
            cnt_after = r_lk_cnt + 1'b1;
        end
        if (int'(cnt_after) > int'(lruc_pkg::OCC_MAX)) begin
            n_occ = lruc_pkg::OCC_MAX;
        end else begin
            n_occ = lruc_pkg::OCC_W'(cnt_after);
        end

        n_state = r_state;
        unique case (r_state)
            S_LOOK:  if (i_head.avail) n_state = S_WRITE;
            S_WRITE: n_state = S_LOOK;
            default: n_state = S_LOOK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (look) begin
            r_op         <= i_head.item.op;
            r_lk_key     <= i_head.item.key;
            r_lk_payload <= i_head.item.payload;
            r_lk_hit     <= match && (i_head.item.op != lruc_pkg::OP_CLEAR);
            r_lk_evict   <= (i_head.item.op == lruc_pkg::OP_PUT) && !match && full;
            r_lk_idx     <= match ? match_idx : (full ? ti[1] : free_idx);
            r_lk_data    <= r_payload[match_idx];
            r_lk_cnt     <= cnt;
        end
        if (bump) begin
            r_stamp[r_lk_idx] <= n_count;
        end
        if (store) begin
            r_key[r_lk_idx]     <= r_lk_key;
            r_payload[r_lk_idx] <= r_lk_payload;
        end
        if (r_state == S_WRITE) begin
            r_hit   <= r_lk_hit;
            r_data  <= ((r_op == lruc_pkg::OP_GET) && r_lk_hit) ? r_lk_data : '0;
            r_evict <= r_lk_evict;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOOK;
            r_valid  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_strobe <= (r_state == S_WRITE);
            if (bump) begin
                r_count <= n_count;
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_hit       = r_hit;
    assign o_data      = r_data;
    assign o_evicted   = r_evict;
    assign o_occupancy = r_occ;

endmodule

### rtl/lru_associative_cache.sv
// Top level of the fully associative LRU cache: active-slot register and
// the front/back split. Depends on lruc_pkg, lruc_front and lruc_back.
//
//  channel   handshake                 payload
//  command   start / busy              i_mode, i_key, i_payload
//  result    o_strobe (one cycle)      o_hit, o_data, o_evicted, o_occupancy
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (active slot count)
//
// A command is taken when start is high and busy is low and lands in a
// two-entry queue. The back end handles each command as a tag match and
// oldest-stamp search followed by a slot update, and takes up the next
// command only after that update; the result is registered in the update step.
// busy rises only when the queue is full. Results cannot be held off.
// Synchronous active-low reset empties all slots, zeroes the access counter
// and sets the active count to eight; no clearing pass is needed.
module lru_associative_cache #(
    parameter int SLOTS      = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lruc_pkg::MODE_W-1:0]     i_mode,
    input  logic [lruc_pkg::KEY_W-1:0]      i_key,
    input  logic [lruc_pkg::PAYLOAD_W-1:0]  i_payload,
    output logic                            o_strobe,
    output logic                            o_hit,
    output logic [lruc_pkg::PAYLOAD_W-1:0]  o_data,
    output logic                            o_evicted,
    output logic [lruc_pkg::OCC_W-1:0]      o_occupancy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lruc_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [lruc_pkg::CFG_W-1:0] r_active_slots;
    logic [SLOTS-1:0]           active_mask;
    lruc_pkg::t_q_head          head;
    logic                       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= lruc_pkg::ACTIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active_slots <= i_cfg_data;
        end
    end

    // Zero acts as one; counts above SLOTS enable every slot
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            active_mask[i] = (i == 0) || (i < int'(r_active_slots));
        end
    end

    lruc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_mode    (i_mode),
        .i_key     (i_key),
        .i_payload (i_payload),
        .o_head    (head),
        .i_pop     (pop)
    );

    lruc_back #(
        .SLOTS      (SLOTS),
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_active    (active_mask),
        .o_strobe    (o_strobe),
        .o_hit       (o_hit),
        .o_data      (o_data),
        .o_evicted   (o_evicted),
        .o_occupancy (o_occupancy)
    );

endmodule
